// ===== rtl/core/lcfd_pkg.sv =====
package lcfd_pkg;

	// APB register map: one 32-bit register every four bytes
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// Register index taken from the word address bit
	localparam logic REG_START_MARKER   = 1'b0;
	localparam logic REG_EXPECTED_CHECK = 1'b1;

	// Header and trailer field sizes in bytes
	localparam logic [15:0] FIELD_BYTES = 16'd2;

	// Parser phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_LEN   = 5'b00010,
		PH_COPY  = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CHECK = 5'b10000
	} phase_t;

	// Configuration seen by the parser
	typedef struct packed {
		logic [7:0]  start_marker;
		logic [15:0] expected_check;
	} cfg_t;

	// One result per received byte
	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic        frame_done;
		logic        frame_good;
		logic        header_error;
		logic [15:0] frame_length;
	} res_t;

endpackage

// ===== rtl/core/lcfd_regs.sv =====
module lcfd_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lcfd_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [lcfd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [lcfd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output lcfd_pkg::cfg_t                     cfg
);
	import lcfd_pkg::*;

	logic        wr_en;
	logic        reg_sel;
	logic [7:0]  start_marker_q;
	logic [15:0] expected_check_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	// Write a register at the access phase of a write request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q   <= '0;
			expected_check_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_START_MARKER:   start_marker_q   <= pwdata[7:0];
				REG_EXPECTED_CHECK: expected_check_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_START_MARKER:   prdata = {24'd0, start_marker_q};
			REG_EXPECTED_CHECK: prdata = {16'd0, expected_check_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.start_marker   = start_marker_q;
	assign cfg.expected_check = expected_check_q;

endmodule

// ===== rtl/core/lcfd_parser.sv =====
module lcfd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  lcfd_pkg::cfg_t cfg,
	input  logic           advance,
	input  logic [7:0]     rx_byte,
	output lcfd_pkg::res_t res
);
	import lcfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [15:0] length_word_q, length_word_d;
	logic [15:0] length_copy_q, length_copy_d;
	logic [15:0] check_word_q, check_word_d;
	logic [15:0] left_dec;
	logic        left_zero;

	assign left_dec  = bytes_left_q - 16'd1;
	assign left_zero = (left_dec == 16'd0);

	// Decode one byte against the current phase
	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		length_word_d = length_word_q;
		length_copy_d = length_copy_q;
		check_word_d  = check_word_q;
		res           = '0;
		unique case (phase_q)
			PH_LEN: begin
				length_word_d = {length_word_q[7:0], rx_byte};
				bytes_left_d  = left_dec;
				if (left_zero) begin
					phase_d       = PH_COPY;
					length_copy_d = '0;
					bytes_left_d  = FIELD_BYTES;
				end
			end
			PH_COPY: begin
				length_copy_d = {length_copy_q[7:0], rx_byte};
				bytes_left_d  = left_dec;
				if (left_zero) begin
					if (length_copy_d != length_word_q) begin
						res.header_error = 1'b1;
						phase_d          = PH_HUNT;
					end else if (length_word_q == 16'd0) begin
						phase_d      = PH_CHECK;
						bytes_left_d = FIELD_BYTES;
						check_word_d = '0;
					end else begin
						phase_d      = PH_DATA;
						bytes_left_d = length_word_q;
					end
				end
			end
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				bytes_left_d      = left_dec;
				if (left_zero) begin
					res.payload_last = 1'b1;
					phase_d          = PH_CHECK;
					bytes_left_d     = FIELD_BYTES;
					check_word_d     = '0;
				end
			end
			PH_CHECK: begin
				check_word_d = {check_word_q[7:0], rx_byte};
				bytes_left_d = left_dec;
				if (left_zero) begin
					res.frame_done = 1'b1;
					res.frame_good = (check_word_d == cfg.expected_check);
					phase_d        = PH_HUNT;
				end
			end
			default: begin
				// Hunt for the start marker
				phase_d = PH_HUNT;
				if (rx_byte == cfg.start_marker) begin
					phase_d       = PH_LEN;
					length_word_d = '0;
					bytes_left_d  = FIELD_BYTES;
				end
			end
		endcase
		res.frame_length = length_word_d;
	end

	// Advance the parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			bytes_left_q  <= '0;
			length_word_q <= '0;
			length_copy_q <= '0;
			check_word_q  <= '0;
		end else if (advance) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			length_word_q <= length_word_d;
			length_copy_q <= length_copy_d;
			check_word_q  <= check_word_d;
		end
	end

	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res.payload_last |-> res.payload_valid)
		else $error("payload_last without payload_valid");

	a_good_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.frame_good |-> res.frame_done)
		else $error("frame_good without frame_done");

	a_data_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_left_q != 16'd0)
		else $error("payload phase with no bytes left");

	a_herr_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.header_error |=> phase_q == PH_HUNT)
		else $error("header error did not return to hunting");

endmodule

// ===== rtl/core/lcfd_skid.sv =====
module lcfd_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcfd_pkg::res_t push_res,
	output logic           space,
	output logic           out_valid,
	input  logic           out_ready,
	output lcfd_pkg::res_t out_res
);
	import lcfd_pkg::*;

	logic main_v_q;
	logic skid_v_q;
	res_t main_q;
	res_t skid_q;
	logic pop;

	assign space     = ~skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;
	assign pop       = main_v_q & out_ready;

	// Track occupancy of the output and skid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	// Move result payloads between slots
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid slot filled while output slot empty");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		main_v_q && !out_ready |=> main_v_q)
		else $error("stalled result dropped");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !push)
		else $error("request accepted with both slots full");

endmodule

// ===== rtl/core/length_checked_frame_deframer.sv =====
// Byte-stream deframer for start-marker, length-prefixed frames.
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per
// request. Each byte gives exactly one result on the output channel
// (out_valid/out_ready): payload_valid/payload_byte/payload_last for payload
// bytes, header_error when the length copy mismatches, frame_done/frame_good
// on the second check byte, and frame_length for the current frame.
// The APB port holds start_marker (address 0) and expected_check (address 4);
// pready is always high. Write them only while the block is idle.
// Each result is registered in the output or skid slot when its byte is accepted.
// Throughput: one byte per cycle while in_ready is high, set by the phase update
// between the input and the result register.
// When the receiver stalls, a two-slot output buffer keeps in_ready high for
// one more byte; in_ready then drops until the receiver takes a result.
// Reset clears both registers to zero, returns the parser to hunting and
// empties the output buffer.
module length_checked_frame_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lcfd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lcfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lcfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            payload_valid,
	output logic [7:0]                      payload_byte,
	output logic                            payload_last,
	output logic                            frame_done,
	output logic                            frame_good,
	output logic                            header_error,
	output logic [15:0]                     frame_length
);
	import lcfd_pkg::*;

	cfg_t cfg;
	res_t step_res;
	res_t out_res;
	logic accept;
	logic space;

	assign in_ready = space;
	assign accept   = in_valid & space;

	lcfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.rx_byte (rx_byte),
		.res     (step_res)
	);

	lcfd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_res  (step_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Drive the result fields
	assign payload_valid = out_res.payload_valid;
	assign payload_byte  = out_res.payload_byte;
	assign payload_last  = out_res.payload_last;
	assign frame_done    = out_res.frame_done;
	assign frame_good    = out_res.frame_good;
	assign header_error  = out_res.header_error;
	assign frame_length  = out_res.frame_length;

endmodule
